// File: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY          = 256;
  localparam int VALUE_BITS        = 16;
  localparam int PRIORITY_BITS     = 16;
  localparam int COUNT_BITS        = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_BITS  = 9;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_POP    = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0]    value;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic   insert;
    logic   pop;
    entry_t fresh;
  } cell_cmd_t;

endpackage

// File: rtl/core/sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a sorted shift chain of cells.
// ----------------------------------------------------------------------------
// Takes one insert or pop word per clock unless stalled and returns one result
// word in the next cycle from an output register; cmd_stall rises only while
// that register holds a result that the consumer is stalling. Every cell
// compares its priority with an insert in parallel and the whole chain shifts
// at once, so throughput is one word per cycle regardless of occupancy. The
// queue holds CAPACITY entries; equal priorities leave newest first.
module sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic                                action,
  input  logic [spq_pkg::VALUE_BITS-1:0]      item_value,
  input  logic [spq_pkg::PRIORITY_BITS-1:0]   item_priority,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [spq_pkg::VALUE_BITS-1:0]      popped_value,
  output logic                                popped_valid,
  output logic [1:0]                          status,
  output logic [spq_pkg::ENTRY_COUNT_BITS-1:0] entry_count
);
  import spq_pkg::*;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  do_insert;
  logic                  do_pop;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  status_t               status_next;
  cell_cmd_t             cmd;
  entry_t                entries [CAPACITY];
  logic [CAPACITY-1:0]   shifts;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = (count == COUNT_BITS'(CAPACITY));
  assign empty     = (count == '0);
  assign do_insert = accept && (action_t'(action) == ACT_INSERT) && !full;
  assign do_pop    = accept && (action_t'(action) == ACT_POP) && !empty;

  assign cmd.insert      = do_insert;
  assign cmd.pop         = do_pop;
  assign cmd.fresh.value = item_value;
  assign cmd.fresh.prio  = item_priority;

  always_comb begin
    count_next  = count;
    status_next = STATUS_DONE;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_pop) begin
      count_next = count - 1'b1;
    end else if (action_t'(action) == ACT_INSERT) begin
      status_next = STATUS_FULL;
    end else begin
      status_next = STATUS_EMPTY;
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic   prev_shift;
      entry_t prev_entry;
      entry_t next_entry;

      if (i == 0) begin : g_head
        assign prev_shift = 1'b0;
        assign prev_entry = '0;
      end else begin : g_body
        assign prev_shift = shifts[i-1];
        assign prev_entry = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
        assign next_entry = '0;
      end else begin : g_below
        assign next_entry = entries[i+1];
      end

      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (count > COUNT_BITS'(i)),
        .at_tail    (count == COUNT_BITS'(i)),
        .prev_shift (prev_shift),
        .prev_entry (prev_entry),
        .next_entry (next_entry),
        .shift      (shifts[i]),
        .entry      (entries[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result word; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= do_pop ? entries[0].value : '0;
      popped_valid <= do_pop;
      status       <= status_next;
      entry_count  <= ENTRY_COUNT_BITS'(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> count == $past(count) + 1'b1)
    else $error("insert did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_pop |=> count == $past(count) - 1'b1)
    else $error("pop did not shrink the queue");

  a_popped_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && popped_valid |-> status == STATUS_DONE)
    else $error("popped entry with error status");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == STATUS_EMPTY |-> entry_count == '0 && !popped_valid)
    else $error("empty pop reported entries");
`endif

endmodule

// File: rtl/core/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with an incoming
// insert and takes from its lower or upper neighbor as the chain shifts.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               at_tail,
  input  logic               prev_shift,
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               shift,
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  // Occupied slots at or above the insert point move up by one.
  assign shift = occupied && (cmd.fresh.prio <= entry.prio);

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (prev_shift) begin
        entry <= prev_entry;
      end else if (shift || at_tail) begin
        entry <= cmd.fresh;
      end
    end else if (cmd.pop) begin
      entry <= next_entry;
    end
  end

endmodule

// File: tb/sv/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue.
// ----------------------------------------------------------------------------
// A driver feeds insert and pop words from a list built at time zero. A
// shadow copy of the sorted store, updated on every accepted word, gives the
// result that word must return. A monitor compares each result word in order.
// The stimulus starts with a few directed words: pops on an empty queue,
// extreme keys, and ties at both ends. Random runs then fill the queue past
// capacity and drain it past empty. Both sides stall in random bursts, and
// the receiver holds off once for a long stretch to back up the input.
module tb_sorted_priority_queue;

  localparam int CAP          = spq_pkg::CAPACITY;
  localparam int VW           = spq_pkg::VALUE_BITS;
  localparam int PW           = spq_pkg::PRIORITY_BITS;
  localparam int CW           = spq_pkg::ENTRY_COUNT_BITS;
  localparam int RANDOM_WORDS = 1850;
  localparam int CALM_TAIL    = 150;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT_WORD = 450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct {
    spq_pkg::action_t act;
    logic [VW-1:0]    value;
    logic [PW-1:0]    prio;
    bit               wait_empty;   // sender pauses until all results are back
  } cmd_word_t;

  typedef struct {
    logic [VW-1:0]    value;
    logic             returned;
    spq_pkg::status_t st;
    logic [CW-1:0]    count;
  } rsp_word_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cmd_valid = 1'b0;
  logic          cmd_stall;
  logic          action = 1'b0;
  logic [VW-1:0] item_value = '0;
  logic [PW-1:0] item_priority = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  logic [VW-1:0] popped_value;
  logic          popped_valid;
  logic [1:0]    status;
  logic [CW-1:0] entry_count;

  // shadow of the sorted store, slot 0 holds the smallest key
  logic [PW-1:0] shadow_prio [CAP];
  logic [VW-1:0] shadow_val  [CAP];
  int            shadow_count = 0;

  cmd_word_t cmd_words[$];
  rsp_word_t result_words[$];

  int fail_count   = 0;
  int words_in     = 0;
  int words_out    = 0;
  int n_inserted   = 0;
  int n_dropped    = 0;
  int n_popped     = 0;
  int n_empty_pops = 0;
  int peak_count   = 0;

  sorted_priority_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .action        (action),
    .item_value    (item_value),
    .item_priority (item_priority),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .popped_value  (popped_value),
    .popped_valid  (popped_valid),
    .status        (status),
    .entry_count   (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one word to the shadow store and returns the result it yields.
  function automatic rsp_word_t queue_op(input cmd_word_t w);
    rsp_word_t r;
    int        pos;
    r.value    = '0;
    r.returned = 1'b0;
    r.st       = spq_pkg::STATUS_DONE;
    if (w.act == spq_pkg::ACT_INSERT) begin
      if (shadow_count >= CAP) begin
        r.st = spq_pkg::STATUS_FULL;
        n_dropped++;
      end else begin
        pos = shadow_count;
        for (int k = 0; k < shadow_count; k++) begin
          if (w.prio <= shadow_prio[k]) begin
            pos = k;
            break;
          end
        end
        for (int k = shadow_count; k > pos; k--) begin
          shadow_prio[k] = shadow_prio[k-1];
          shadow_val[k]  = shadow_val[k-1];
        end
        shadow_prio[pos] = w.prio;
        shadow_val[pos]  = w.value;
        shadow_count++;
        n_inserted++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
    end else if (shadow_count == 0) begin
      r.st = spq_pkg::STATUS_EMPTY;
      n_empty_pops++;
    end else begin
      r.value    = shadow_val[0];
      r.returned = 1'b1;
      for (int k = 1; k < shadow_count; k++) begin
        shadow_prio[k-1] = shadow_prio[k];
        shadow_val[k-1]  = shadow_val[k];
      end
      shadow_count--;
      n_popped++;
    end
    r.count = shadow_count[CW-1:0];
    return r;
  endfunction

  task automatic add_word(input spq_pkg::action_t act, input logic [VW-1:0] v,
                          input logic [PW-1:0] p, input bit wait_empty = 1'b0);
    cmd_word_t w;
    w.act        = act;
    w.value      = v;
    w.prio       = p;
    w.wait_empty = wait_empty;
    cmd_words.push_back(w);
  endtask

  // n random words, ins_pct percent inserts, keys drawn from 0..prio_max
  task automatic add_run(input int n, input int ins_pct, input int prio_max);
    for (int i = 0; i < n; i++) begin
      add_word(($urandom_range(1, 100) <= ins_pct) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_POP,
               VW'($urandom), PW'($urandom_range(0, prio_max)));
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    int        gap_left;
    cmd_word_t w;
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        result_words.push_back(queue_op(cmd_words.pop_front()));
        words_in++;
      end
      // a stalled word stays on the bus untouched
      if (!(cmd_valid && cmd_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_valid <= 1'b0;
        end else if (cmd_words.size() == 0) begin
          cmd_valid <= 1'b0;
        end else if (cmd_words[0].wait_empty && result_words.size() != 0) begin
          cmd_valid <= 1'b0;
        end else if (cmd_words.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 12) - 1;
          cmd_valid <= 1'b0;
        end else begin
          w = cmd_words[0];
          cmd_valid     <= 1'b1;
          action        <= w.act;
          item_value    <= w.value;
          item_priority <= w.prio;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin : watch_proc
    int        stall_left;
    int        hold_left;
    bit        hold_done;
    rsp_word_t r;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        words_out++;
        if (result_words.size() == 0) begin
          $error("result word arrived with nothing outstanding");
          fail_count++;
        end else begin
          r = result_words.pop_front();
          field_check("popped_value", 32'(r.value), 32'(popped_value));
          field_check("popped_valid", 32'(r.returned), 32'(popped_valid));
          field_check("status", 32'(r.st), 32'(status));
          field_check("entry_count", 32'(r.count), 32'(entry_count));
        end
      end
      // long hold-off while the sender keeps going, so the input backs up
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!hold_done && words_in >= HOLD_AT_WORD) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (cmd_words.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog: too long without any word moving on either side
  always @(posedge clk) begin : dog_proc
    int idle_cycles;
    if (rst) begin
      idle_cycles = 0;
    end else if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: %0d words in, %0d out, %0d outstanding",
                 words_in, words_out, result_words.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stim_proc
    int mode_pct;
    int mode_prio;

    // empty pop, extreme keys, ties at both ends (newest tie leaves first)
    add_word(spq_pkg::ACT_POP,    16'h0000, 16'h0000);
    add_word(spq_pkg::ACT_INSERT, 16'h0000, 16'h0000);
    add_word(spq_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF);
    add_word(spq_pkg::ACT_INSERT, 16'h1234, 16'hFFFF);
    add_word(spq_pkg::ACT_INSERT, 16'hA5A5, 16'h0000);
    add_word(spq_pkg::ACT_INSERT, 16'h5A5A, 16'h8000);
    repeat (5) add_word(spq_pkg::ACT_POP, 16'h0000, 16'h0000);
    add_word(spq_pkg::ACT_POP,    16'hFFFF, 16'hFFFF);
    add_word(spq_pkg::ACT_INSERT, 16'hFFFF, 16'h0001);
    add_word(spq_pkg::ACT_POP,    16'hFFFF, 16'hFFFF);
    add_word(spq_pkg::ACT_POP,    16'h5555, 16'hAAAA);

    add_run(300, 50, 15);
    add_run(280, 100, 65535);   // fills past capacity
    add_run(120, 60, 65535);    // churn near full
    add_run(300, 0, 65535);     // drains past empty
    add_word(spq_pkg::ACT_INSERT, VW'($urandom), PW'($urandom), 1'b1);
    while (cmd_words.size() < RANDOM_WORDS) begin
      case ($urandom_range(0, 3))
        0: mode_pct = 25;
        1: mode_pct = 50;
        2: mode_pct = 75;
        default: mode_pct = 90;
      endcase
      case ($urandom_range(0, 2))
        0: mode_prio = 3;
        1: mode_prio = 255;
        default: mode_prio = 65535;
      endcase
      add_run($urandom_range(50, 150), mode_pct, mode_prio);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (cmd_words.size() != 0 || result_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d inserts, %0d dropped when full, %0d pops, %0d empty pops",
             words_in, n_inserted, n_dropped, n_popped, n_empty_pops);
    $display("Peak occupancy %0d of %0d, %0d result words checked", peak_count, CAP,
             words_out);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
